FILE: sv/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and codes of the retransmit timeout tracker.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // input item modes
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // configuration register indexes
  localparam logic [7:0] CFG_TIMEOUT    = 8'd0;
  localparam logic [7:0] CFG_IDLE_LIMIT = 8'd1;

  // configuration reset values
  localparam logic [7:0] TIMEOUT_RST    = 8'd2;
  localparam logic [7:0] IDLE_LIMIT_RST = 8'd8;

  typedef enum logic [3:0] {
    KIND_SENT       = 4'd0,
    KIND_SEQ_BUSY   = 4'd1,
    KIND_EXHAUSTED  = 4'd2,
    KIND_ACKED      = 4'd3,
    KIND_NOT_PEND   = 4'd4,
    KIND_ACK_RANGE  = 4'd5,
    KIND_RETRANSMIT = 4'd6,
    KIND_SCAN_DONE  = 4'd7,
    KIND_STOPPED    = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

FILE: sv/retransmit_timeout_tracker.sv
// ----------------------------------------------------------------------------
// retransmit_timeout_tracker
// Timer table for an ARQ sender: tracks pending sequence numbers, clears them
// on ack and reports entries past the timeout on each scan tick.
// ----------------------------------------------------------------------------
//
//  channel  signals                                     direction
//  -------  ------------------------------------------  ---------
//  in       in_valid/in_ready, in_mode, in_ack_seq      input
//  out      out_valid/out_ready, out_kind, out_seq,     output
//           out_pending_count, out_last
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_wdata   input
//
//  Send, ack and a tick while stopped load their result into the output
//  register at the accept edge; mode 3 is dropped.
//  After the accept, a scan tick steps each entry through a stamp memory read
//  (ST_READ) and a compare/write-back (ST_EVAL), then closes in ST_DONE.
//  Reset is synchronous and clears all control state; the stamp memory is
//  left as is, since a stamp only counts for a pending entry.
//  A stalled output register holds the scan at an expired entry or at the close.
//
module retransmit_timeout_tracker #(
  parameter int TABLE_DEPTH = 32,
  parameter int STAMP_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic signed [7:0] in_ack_seq,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_kind,
  output logic [7:0]        out_seq,
  output logic [6:0]        out_pending_count,
  output logic              out_last,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);
  import rtt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SEQ_W = $clog2(TABLE_DEPTH + 1);

  // control state
  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     hit_r, hit_nxt;
  logic [SEQ_W-1:0]         next_seq_r, next_seq_nxt;
  logic [STAMP_WIDTH-1:0]   now_r, now_nxt;
  logic [6:0]               outstanding_r, outstanding_nxt;
  logic [7:0]               idle_r, idle_nxt;
  logic                     stopped_r, stopped_nxt;
  logic [TABLE_DEPTH-1:0]   pend_r, pend_nxt;
  logic [7:0]               timeout_r;
  logic [7:0]               idle_limit_r;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  kind_t                    out_kind_r, out_kind_nxt;
  logic [7:0]               out_seq_r, out_seq_nxt;
  logic [6:0]               out_cnt_r, out_cnt_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_load;
  logic                     out_free;

  // stamp memory
  logic [STAMP_WIDTH-1:0]   stamp_mem [TABLE_DEPTH];
  logic [STAMP_WIDTH-1:0]   rd_data_r;
  logic                     mem_re;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;

  logic                     in_fire;
  logic [STAMP_WIDTH-1:0]   age;
  logic                     expired;
  logic [7:0]               idle_inc;
  logic [IDX_W-1:0]         send_idx;
  logic [IDX_W-1:0]         ack_idx;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign send_idx = next_seq_r[IDX_W-1:0];
  assign ack_idx  = in_ack_seq[IDX_W-1:0];

  assign age      = now_r - rd_data_r;
  assign expired  = pend_r[idx_r] && (age > STAMP_WIDTH'(timeout_r));
  assign idle_inc = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    hit_nxt         = hit_r;
    next_seq_nxt    = next_seq_r;
    now_nxt         = now_r;
    outstanding_nxt = outstanding_r;
    idle_nxt        = idle_r;
    stopped_nxt     = stopped_r;
    pend_nxt        = pend_r;
    out_load        = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_seq_nxt     = out_seq_r;
    out_last_nxt    = out_last_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_SEND: begin
              out_load     = 1'b1;
              out_last_nxt = 1'b1;
              out_seq_nxt  = 8'(next_seq_r);
              if (next_seq_r >= SEQ_W'(TABLE_DEPTH)) begin
                out_kind_nxt = KIND_EXHAUSTED;
              end else begin
                next_seq_nxt = next_seq_r + SEQ_W'(1);
                if (pend_r[send_idx]) begin
                  out_kind_nxt = KIND_SEQ_BUSY;
                end else begin
                  pend_nxt[send_idx] = 1'b1;
                  mem_we             = 1'b1;
                  mem_waddr          = send_idx;
                  outstanding_nxt    = outstanding_r + 7'd1;
                  out_kind_nxt       = KIND_SENT;
                end
              end
            end
            MODE_ACK: begin
              out_load     = 1'b1;
              out_last_nxt = 1'b1;
              out_seq_nxt  = in_ack_seq;
              // negative values land above 127 and fail the same compare
              if ($unsigned(in_ack_seq) >= 8'(TABLE_DEPTH)) begin
                out_kind_nxt = KIND_ACK_RANGE;
              end else if (!pend_r[ack_idx]) begin
                out_kind_nxt = KIND_NOT_PEND;
              end else begin
                pend_nxt[ack_idx] = 1'b0;
                outstanding_nxt   = outstanding_r - 7'd1;
                out_kind_nxt      = KIND_ACKED;
              end
            end
            MODE_TICK: begin
              if (stopped_r) begin
                out_load     = 1'b1;
                out_last_nxt = 1'b1;
                out_seq_nxt  = 8'd0;
                out_kind_nxt = KIND_STOPPED;
              end else begin
                now_nxt   = now_r + STAMP_WIDTH'(1);
                idx_nxt   = '0;
                hit_nxt   = 1'b0;
                state_nxt = ST_READ;
              end
            end
            default: begin
              // unused mode: drop the item
            end
          endcase
        end
      end

      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        // the write-back goes to idx_r, the next read to idx_r+1: no overlap
        if (!expired || out_free) begin
          if (expired) begin
            mem_we       = 1'b1;
            out_load     = 1'b1;
            out_kind_nxt = KIND_RETRANSMIT;
            out_seq_nxt  = 8'(idx_r);
            out_last_nxt = 1'b0;
            hit_nxt      = 1'b1;
          end
          if (idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_READ;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = KIND_SCAN_DONE;
          out_seq_nxt  = 8'd0;
          out_last_nxt = 1'b1;
          if (hit_r) begin
            idle_nxt = 8'd0;
          end else begin
            idle_nxt = idle_inc;
            if (idle_inc >= idle_limit_r) begin
              stopped_nxt = 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_cnt_nxt   = out_load ? outstanding_nxt : out_cnt_r;
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      hit_r         <= 1'b0;
      next_seq_r    <= '0;
      now_r         <= '0;
      outstanding_r <= '0;
      idle_r        <= '0;
      stopped_r     <= 1'b0;
      pend_r        <= '0;
      out_valid_r   <= 1'b0;
      timeout_r     <= TIMEOUT_RST;
      idle_limit_r  <= IDLE_LIMIT_RST;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      hit_r         <= hit_nxt;
      next_seq_r    <= next_seq_nxt;
      now_r         <= now_nxt;
      outstanding_r <= outstanding_nxt;
      idle_r        <= idle_nxt;
      stopped_r     <= stopped_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIMEOUT) begin
          timeout_r <= cfg_wdata;
        end else if (cfg_index == CFG_IDLE_LIMIT) begin
          idle_limit_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  // stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_waddr] <= now_nxt;
    end
    if (mem_re) begin
      rd_data_r <= stamp_mem[idx_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_seq           = out_seq_r;
  assign out_pending_count = out_cnt_r;
  assign out_last          = out_last_r;

  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r == 7'($countones(pend_r)))
    else $error("outstanding count differs from pending flags");

  a_seq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_seq_r <= SEQ_W'(TABLE_DEPTH))
    else $error("next sequence number beyond table");

  a_writeback_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_EVAL) |-> (out_load && out_kind_nxt == KIND_RETRANSMIT))
    else $error("stamp restamped without a retransmit item");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_TICK && !stopped_r) |=> (state_r == ST_READ && idx_r == '0))
    else $error("tick did not start scan at entry zero");

endmodule
